>>> rtl/slx_pkg.sv
// ----------------------------------------------------------------------------
// slx_pkg
// Types and constants shared by the command line lexer modules.
// ----------------------------------------------------------------------------
package slx_pkg;

  // token kinds
  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_WEND   = 3'd1;
  localparam logic [2:0] KIND_PIPE   = 3'd2;
  localparam logic [2:0] KIND_OUT    = 3'd3;
  localparam logic [2:0] KIND_APPEND = 3'd4;
  localparam logic [2:0] KIND_IN     = 3'd5;
  localparam logic [2:0] KIND_BG     = 3'd6;
  localparam logic [2:0] KIND_LEND   = 3'd7;

  // characters with a meaning to the lexer
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // result slots of one byte, in emission order
  localparam int unsigned NUM_SLOTS = 6;
  localparam logic [2:0] SLOT_GT    = 3'd0;  // held > resolved: out or append
  localparam logic [2:0] SLOT_MAIN  = 3'd1;  // result of the byte itself
  localparam logic [2:0] SLOT_EGT   = 3'd2;  // line end: held > as out
  localparam logic [2:0] SLOT_ESC   = 3'd3;  // line end: trailing backslash space
  localparam logic [2:0] SLOT_WEND  = 3'd4;  // line end: word end
  localparam logic [2:0] SLOT_LEND  = 3'd5;  // line end token

  typedef struct packed {
    logic [7:0] byte_in;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_out;
    logic       last;
  } out_beat_t;

  // one classified byte waiting for the back end
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slot_mask;
    logic                 gt_append;
    logic [2:0]           main_kind;
    logic [7:0]           main_byte;
  } slx_entry_t;

endpackage

>>> rtl/slx_front.sv
// ----------------------------------------------------------------------------
// slx_front
// Classifies each input byte against the quote, escape and word state and
// builds the set of result slots that the byte produces.
// ----------------------------------------------------------------------------
module slx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  slx_pkg::in_beat_t   in_beat,
  output logic                push,
  output slx_pkg::slx_entry_t push_entry
);

  logic sq_r, dq_r, esc_r, wo_r, gt_r;
  logic sq_nxt, dq_nxt, esc_nxt, wo_nxt, gt_nxt;
  logic [7:0] c;
  logic       consumed;
  logic       is_ws;
  logic       main_v;
  logic [2:0] main_kind;
  logic [slx_pkg::NUM_SLOTS-1:0] mask;

  assign c = in_beat.byte_in;

  // byte classification and next state
  always_comb begin
    is_ws     = (c inside {slx_pkg::CH_SPACE, [slx_pkg::CH_TAB:slx_pkg::CH_CR]});
    consumed  = gt_r && (c == slx_pkg::CH_GT);
    sq_nxt    = sq_r;
    dq_nxt    = dq_r;
    esc_nxt   = esc_r;
    wo_nxt    = wo_r;
    gt_nxt    = 1'b0;
    main_v    = 1'b0;
    main_kind = slx_pkg::KIND_CHAR;
    if (!consumed) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        main_v  = 1'b1;
        wo_nxt  = 1'b1;
      end else if (c == slx_pkg::CH_BSLASH && !sq_r) begin
        esc_nxt = 1'b1;
      end else if (c == slx_pkg::CH_SQUOTE && !dq_r) begin
        sq_nxt = !sq_r;
      end else if (c == slx_pkg::CH_DQUOTE && !sq_r) begin
        dq_nxt = !dq_r;
      end else if (sq_r || dq_r) begin
        main_v = 1'b1;
        wo_nxt = 1'b1;
      end else if (is_ws) begin
        if (wo_r) begin
          main_v    = 1'b1;
          main_kind = slx_pkg::KIND_WEND;
          wo_nxt    = 1'b0;
        end
      end else if (!wo_r && c == slx_pkg::CH_PIPE) begin
        main_v    = 1'b1;
        main_kind = slx_pkg::KIND_PIPE;
      end else if (!wo_r && c == slx_pkg::CH_LT) begin
        main_v    = 1'b1;
        main_kind = slx_pkg::KIND_IN;
      end else if (!wo_r && c == slx_pkg::CH_AMP) begin
        main_v    = 1'b1;
        main_kind = slx_pkg::KIND_BG;
      end else if (!wo_r && c == slx_pkg::CH_GT) begin
        gt_nxt = 1'b1;
      end else begin
        main_v = 1'b1;
        wo_nxt = 1'b1;
      end
    end
  end

  // slot set for this byte
  always_comb begin
    mask                  = '0;
    mask[slx_pkg::SLOT_GT]   = gt_r;
    mask[slx_pkg::SLOT_MAIN] = main_v;
    if (in_beat.line_end) begin
      mask[slx_pkg::SLOT_EGT]  = gt_nxt;
      mask[slx_pkg::SLOT_ESC]  = esc_nxt;
      mask[slx_pkg::SLOT_WEND] = wo_nxt || esc_nxt;
      mask[slx_pkg::SLOT_LEND] = 1'b1;
    end
  end

  assign push                 = in_fire && (|mask);
  assign push_entry.slot_mask = mask;
  assign push_entry.gt_append = consumed;
  assign push_entry.main_kind = main_kind;
  assign push_entry.main_byte = c;

  // mode flags, cleared at line end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= 1'b0;
      dq_r  <= 1'b0;
      esc_r <= 1'b0;
      wo_r  <= 1'b0;
      gt_r  <= 1'b0;
    end else if (in_fire) begin
      if (in_beat.line_end) begin
        sq_r  <= 1'b0;
        dq_r  <= 1'b0;
        esc_r <= 1'b0;
        wo_r  <= 1'b0;
        gt_r  <= 1'b0;
      end else begin
        sq_r  <= sq_nxt;
        dq_r  <= dq_nxt;
        esc_r <= esc_nxt;
        wo_r  <= wo_nxt;
        gt_r  <= gt_nxt;
      end
    end
  end

endmodule

>>> rtl/slx_queue.sv
// ----------------------------------------------------------------------------
// slx_queue
// Small first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module slx_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  slx_pkg::slx_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output slx_pkg::slx_entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  slx_pkg::slx_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/slx_back.sv
// ----------------------------------------------------------------------------
// slx_back
// Walks the slot set of the current byte and sends one token per beat,
// marking the final token of each byte.
// ----------------------------------------------------------------------------
module slx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  slx_pkg::slx_entry_t head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output slx_pkg::out_beat_t  out_data
);

  slx_pkg::slx_entry_t           cur_r;
  logic [slx_pkg::NUM_SLOTS-1:0] mask_r;
  logic [slx_pkg::NUM_SLOTS-1:0] mask_nxt;
  logic [slx_pkg::NUM_SLOTS-1:0] rest;
  logic [2:0]                    idx;
  logic                          fire;

  // lowest pending slot
  always_comb begin
    idx = '0;
    for (int i = slx_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = 3'(i);
      end
    end
  end

  always_comb begin
    rest      = mask_r;
    rest[idx] = 1'b0;
  end

  // token for the selected slot
  always_comb begin
    out_data.byte_out = '0;
    case (idx)
      slx_pkg::SLOT_GT: begin
        out_data.kind = cur_r.gt_append ? slx_pkg::KIND_APPEND : slx_pkg::KIND_OUT;
      end
      slx_pkg::SLOT_MAIN: begin
        out_data.kind = cur_r.main_kind;
        if (cur_r.main_kind == slx_pkg::KIND_CHAR) begin
          out_data.byte_out = cur_r.main_byte;
        end
      end
      slx_pkg::SLOT_EGT:  out_data.kind = slx_pkg::KIND_OUT;
      slx_pkg::SLOT_ESC: begin
        out_data.kind     = slx_pkg::KIND_CHAR;
        out_data.byte_out = slx_pkg::CH_SPACE;
      end
      slx_pkg::SLOT_WEND: out_data.kind = slx_pkg::KIND_WEND;
      slx_pkg::SLOT_LEND: out_data.kind = slx_pkg::KIND_LEND;
      default:            out_data.kind = slx_pkg::KIND_LEND;
    endcase
    out_data.last = (rest == '0);
  end

  assign out_valid = (mask_r != '0);
  assign fire      = out_valid && out_ready;
  // take the next byte once the current one has nothing left to send
  assign pop       = head_valid && (!out_valid || (fire && rest == '0));

  always_comb begin
    mask_nxt = mask_r;
    if (pop) begin
      mask_nxt = head_entry.slot_mask;
    end else if (fire) begin
      mask_nxt = rest;
    end
  end

  // payload of the byte in progress
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_entry;
    end
  end

  // pending slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

>>> rtl/shell_command_line_lexer_unit.sv
// ----------------------------------------------------------------------------
// shell_command_line_lexer_unit
// Streaming command line lexer: bytes in, word characters and operator
// tokens out, with quote, escape and >> handling.
//
//   channel   direction  payload               handshake
//   in_       input      byte_in, line_end     in_valid / in_ready
//   out_      output     kind, byte_out, last  out_valid / out_ready
//
// A byte is classified in the cycle it is accepted and queued; one byte can
// be accepted every cycle while the queue has room. Each queued byte sends
// its 1 to 4 tokens at one token per cycle while out_ready is high. Bytes
// with no token never enter the queue. Reset (rst_n low, synchronous)
// clears the mode flags, the queue and the pending tokens. A stalled output
// fills the queue and only then drops in_ready.
// ----------------------------------------------------------------------------
module shell_command_line_lexer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slx_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output slx_pkg::out_beat_t out_data
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_head_valid;
  slx_pkg::slx_entry_t q_push_entry;
  slx_pkg::slx_entry_t q_head_entry;

  assign in_ready = !q_full;

  // byte classification
  slx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_valid && in_ready),
    .in_beat    (in_data),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // decoupling queue
  slx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  // token sequencing
  slx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shell command line lexer: command line bytes
// go in over a valid/ready channel with random gaps, each accepted beat is
// run through a behavioral lexer model to get its tokens, and every token
// that comes out under random back-pressure is checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  slx_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  slx_pkg::out_beat_t out_data;

  // lexer mode flags as the bench sees them
  logic lx_squote = 1'b0;
  logic lx_dquote = 1'b0;
  logic lx_escape = 1'b0;
  logic lx_word = 1'b0;
  logic lx_gt_held = 1'b0;

  slx_pkg::out_beat_t token_queue[$];
  slx_pkg::out_beat_t burst[0:3];
  int                 burst_n;
  slx_pkg::out_beat_t want;
  int                 tokens_seen = 0;
  int                 errors = 0;
  bit                 idle_en = 1'b1;

  shell_command_line_lexer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // token model
  function automatic void add_token(logic [2:0] kind, logic [7:0] ch);
    burst[burst_n].kind = kind;
    burst[burst_n].byte_out = ch;
    burst[burst_n].last = 1'b0;
    burst_n++;
  endfunction

  function automatic void add_word_char(logic [7:0] ch);
    add_token(slx_pkg::KIND_CHAR, ch);
    lx_word = 1'b1;
  endfunction

  function automatic void predict_tokens(slx_pkg::in_beat_t b);
    logic [7:0] c;
    logic       taken;
    c = b.byte_in;
    taken = 1'b0;
    burst_n = 0;
    // a held > resolves first: >> swallows this byte
    if (lx_gt_held) begin
      lx_gt_held = 1'b0;
      if (c == slx_pkg::CH_GT) begin
        add_token(slx_pkg::KIND_APPEND, 8'h00);
        taken = 1'b1;
      end else begin
        add_token(slx_pkg::KIND_OUT, 8'h00);
      end
    end
    if (!taken) begin
      if (lx_escape) begin
        lx_escape = 1'b0;
        add_word_char(c);
      end else if (c == slx_pkg::CH_BSLASH && !lx_squote) begin
        lx_escape = 1'b1;
      end else if (c == slx_pkg::CH_SQUOTE && !lx_dquote) begin
        lx_squote = !lx_squote;
      end else if (c == slx_pkg::CH_DQUOTE && !lx_squote) begin
        lx_dquote = !lx_dquote;
      end else if (lx_squote || lx_dquote) begin
        add_word_char(c);
      end else if (c == slx_pkg::CH_SPACE ||
                   (c >= slx_pkg::CH_TAB && c <= slx_pkg::CH_CR)) begin
        if (lx_word) begin
          add_token(slx_pkg::KIND_WEND, 8'h00);
          lx_word = 1'b0;
        end
      end else if (!lx_word && c == slx_pkg::CH_PIPE) begin
        add_token(slx_pkg::KIND_PIPE, 8'h00);
      end else if (!lx_word && c == slx_pkg::CH_LT) begin
        add_token(slx_pkg::KIND_IN, 8'h00);
      end else if (!lx_word && c == slx_pkg::CH_AMP) begin
        add_token(slx_pkg::KIND_BG, 8'h00);
      end else if (!lx_word && c == slx_pkg::CH_GT) begin
        lx_gt_held = 1'b1;
      end else begin
        add_word_char(c);
      end
    end
    // line end flushes everything and drops open quotes
    if (b.line_end) begin
      if (lx_gt_held) add_token(slx_pkg::KIND_OUT, 8'h00);
      if (lx_escape) add_word_char(slx_pkg::CH_SPACE);
      if (lx_word) add_token(slx_pkg::KIND_WEND, 8'h00);
      add_token(slx_pkg::KIND_LEND, 8'h00);
      lx_squote = 1'b0;
      lx_dquote = 1'b0;
      lx_escape = 1'b0;
      lx_word = 1'b0;
      lx_gt_held = 1'b0;
    end
    if (burst_n > 0) burst[burst_n-1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) token_queue.insert(token_queue.size(), burst[i]);
  endfunction

  task automatic report_error(string field, int got, int exp_val);
    $display("token %0d: %s is %0h, model gives %0h", tokens_seen, field, got, exp_val);
    errors++;
  endtask

  // result side: random stalls and in-order token check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          report_error("unexpected token kind", out_data.kind, 0);
        end else begin
          want = token_queue.pop_front();
          if (out_data.kind !== want.kind) report_error("kind", out_data.kind, want.kind);
          if (out_data.byte_out !== want.byte_out)
            report_error("byte_out", out_data.byte_out, want.byte_out);
          if (out_data.last !== want.last) report_error("last", out_data.last, want.last);
        end
        tokens_seen++;
      end
      out_ready <= idle_en ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  // send one beat; returns at the edge that accepted it
  task automatic send_byte(logic [7:0] ch, logic eol);
    if (idle_en) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data.byte_in <= ch;
    in_data.line_end <= eol;
    do @(posedge clk); while (!in_ready);
    predict_tokens(in_data);
  endtask

  task automatic send_str(string s, logic eol);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eol && (i == s.len() - 1));
  endtask

  // hold the input until every predicted token is out
  task automatic drain_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // skewed toward lexer-relevant characters, with full-range noise
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'h61 + 8'($urandom_range(25));
    if (r < 40) return slx_pkg::CH_SPACE;
    if (r < 46) return slx_pkg::CH_TAB + 8'($urandom_range(4));
    if (r < 52) return slx_pkg::CH_PIPE;
    if (r < 56) return slx_pkg::CH_LT;
    if (r < 60) return slx_pkg::CH_AMP;
    if (r < 70) return slx_pkg::CH_GT;
    if (r < 76) return slx_pkg::CH_SQUOTE;
    if (r < 82) return slx_pkg::CH_DQUOTE;
    if (r < 88) return slx_pkg::CH_BSLASH;
    return 8'($urandom_range(255));
  endfunction

  // byte extremes, every operator, quotes, escapes, line end flushes
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(slx_pkg::CH_TAB, 1'b0);
    send_str("|<&>>>a ", 1'b0);
    send_str("''|", 1'b0);
    send_str("\"\\\"' \"", 1'b0);
    send_str("'\\'", 1'b0);
    send_byte(8'h0E, 1'b0);
    send_byte(slx_pkg::CH_CR, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(slx_pkg::CH_PIPE, 1'b0);
    send_byte(slx_pkg::CH_BSLASH, 1'b1);
    send_byte(slx_pkg::CH_GT, 1'b1);
    send_str("'a", 1'b1);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_byte(pick_char(), $urandom_range(11) == 0);
  endtask

  // no gaps on either side
  task automatic test_back_to_back(int n);
    idle_en = 1'b0;
    test_random(n);
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_tokens();
    test_random(135);
    drain_tokens();
    test_back_to_back(80);
    test_random(135);
    send_byte(pick_char(), 1'b1);
    drain_tokens();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
